@@ rtl/cdc_pkg.sv @@
// calendar date counter package: beat types, date constants and the small
// lookup functions shared by the date and weekday logic. no dependencies.
package cdc_pkg;

    localparam logic [13:0] YEAR_MAX       = 14'd9999;
    localparam logic [4:0]  FEB_BASE_LEN   = 5'd28;
    localparam logic [4:0]  RESET_DAY      = 5'd1;
    localparam logic [3:0]  RESET_MONTH    = 4'd1;
    localparam logic [13:0] RESET_YEAR     = 14'd2001;
    localparam logic [6:0]  RESET_CENTURY  = 7'd20;
    localparam logic [6:0]  RESET_YIC      = 7'd1;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_MAR      = 4'd3;
    // ceil(2^19 / 100): exact quotient by 100 for every year below 43699
    localparam logic [12:0] RECIP_100      = 13'd5243;
    localparam int          RECIP_SHIFT    = 19;
    localparam logic [8:0]  WEEKDAY_BIAS   = 9'd210;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [13:0] load_year;
    } t_in_beat;

    typedef struct packed {
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [13:0] year_now;
        logic [2:0]  weekday;
        logic        load_rejected;
    } t_out_beat;

    function automatic logic is_leap(input logic [6:0] century, input logic [6:0] yic);
        is_leap = (yic[1:0] == 2'd0) && ((yic != 7'd0) || (century[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
            MONTH_FEB: len = leap ? FEB_BASE_LEN + 5'd1 : FEB_BASE_LEN;
            default:                                   len = 5'd0;
        endcase
        month_length = len;
    endfunction

    // floor(2.6 * m - 0.2) mod 7 with march as m = 1, indexed by calendar month
    function automatic logic [2:0] month_code(input logic [3:0] month);
        logic [2:0] code;
        code = 3'd0;
        case (month)
            4'd1:    code = 3'd0;
            4'd2:    code = 3'd3;
            4'd3:    code = 3'd2;
            4'd4:    code = 3'd5;
            4'd5:    code = 3'd0;
            4'd6:    code = 3'd3;
            4'd7:    code = 3'd5;
            4'd8:    code = 3'd1;
            4'd9:    code = 3'd4;
            4'd10:   code = 3'd6;
            4'd11:   code = 3'd2;
            4'd12:   code = 3'd4;
            default: code = 3'd0;
        endcase
        month_code = code;
    endfunction

    // octal digit folding, 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = {2'b00, x[8:6]} + {2'b00, x[5:3]} + {2'b00, x[2:0]};
        s2 = {2'b00, s1[4:3]} + {1'b0, s1[2:0]};
        s3 = {2'b00, s2[3]} + s2[2:0];
        mod7 = (s3 == 3'd7) ? 3'd0 : s3;
    endfunction

endpackage

@@ rtl/calendar_date_counter.sv @@
// calendar_date_counter: held gregorian date with tick and checked load,
// answering each beat with the date and its weekday. uses cdc_pkg.
// the beat is registered in the date stage, then in the weekday stage
// one beat per cycle when not stalled; the date register is the only loop
// stall on the output backs up through both stages to o_in_stall
// reset: date is 1 january 2001, both stages empty
module calendar_date_counter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cdc_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cdc_pkg::t_out_beat o_out_data
);

    // date stage: held date, also the payload of the first stage
    logic [4:0]  r_day,  n_day;
    logic [3:0]  r_month, n_month;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_cent, n_cent;
    logic [6:0]  r_yic,  n_yic;
    logic        r_rej,  n_rej;
    logic        r_s1_valid;
    logic        r_out_valid;
    cdc_pkg::t_out_beat r_out, n_out;

    logic s2_take;
    logic s1_move;
    logic in_take;

    logic [26:0] ld_prod;
    logic [6:0]  ld_cent;
    logic [13:0] ld_rem;
    logic [6:0]  ld_yic;
    logic        ld_ok;
    logic [4:0]  cur_len;

    logic [6:0]  wd_cent;
    logic [6:0]  wd_yic;
    logic [8:0]  wd_sum;

    assign s2_take    = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && s2_take;
    assign o_in_stall = r_s1_valid && !s2_take;
    assign in_take    = i_in_valid && !o_in_stall;

    // next date
    always_comb begin
        ld_prod = {13'd0, i_in_data.load_year} * {14'd0, cdc_pkg::RECIP_100};
        ld_cent = ld_prod[cdc_pkg::RECIP_SHIFT +: 7];
        ld_rem  = i_in_data.load_year - ({ld_cent, 7'd0} - {2'd0, ld_cent, 5'd0}
                  + {5'd0, ld_cent, 2'd0});
        ld_yic  = ld_rem[6:0];
        ld_ok   = (i_in_data.load_year != 14'd0)
                  && (i_in_data.load_year <= cdc_pkg::YEAR_MAX)
                  && (i_in_data.load_month != 4'd0)
                  && (i_in_data.load_month <= cdc_pkg::MONTH_DEC)
                  && (i_in_data.load_day != 5'd0)
                  && (i_in_data.load_day <= cdc_pkg::month_length(i_in_data.load_month,
                      cdc_pkg::is_leap(ld_cent, ld_yic)));
        cur_len = cdc_pkg::month_length(r_month, cdc_pkg::is_leap(r_cent, r_yic));

        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_cent  = r_cent;
        n_yic   = r_yic;
        n_rej   = 1'b0;
        if (i_in_data.kind == cdc_pkg::KIND_LOAD) begin
            if (ld_ok) begin
                n_day   = i_in_data.load_day;
                n_month = i_in_data.load_month;
                n_year  = i_in_data.load_year;
                n_cent  = ld_cent;
                n_yic   = ld_yic;
            end else begin
                n_rej = 1'b1;
            end
        end else if (r_day >= cur_len) begin
            n_day = 5'd1;
            if (r_month >= cdc_pkg::MONTH_DEC) begin
                n_month = 4'd1;
                if (r_year >= cdc_pkg::YEAR_MAX) begin
                    n_year = 14'd1;
                    n_cent = 7'd0;
                    n_yic  = 7'd1;
                end else begin
                    n_year = r_year + 14'd1;
                    if (r_yic == 7'd99) begin
                        n_yic  = 7'd0;
                        n_cent = r_cent + 7'd1;
                    end else begin
                        n_yic = r_yic + 7'd1;
                    end
                end
            end else begin
                n_month = r_month + 4'd1;
            end
        end else begin
            n_day = r_day + 5'd1;
        end
    end

    // weekday of the held date, january and february in the previous year
    always_comb begin
        wd_cent = r_cent;
        wd_yic  = r_yic;
        if (r_month < cdc_pkg::MONTH_MAR) begin
            if (r_yic == 7'd0) begin
                wd_cent = r_cent - 7'd1;
                wd_yic  = 7'd99;
            end else begin
                wd_yic = r_yic - 7'd1;
            end
        end
        wd_sum = {4'd0, r_day} + {6'd0, cdc_pkg::month_code(r_month)}
                 + {2'd0, wd_yic} + {4'd0, wd_yic[6:2]} + {4'd0, wd_cent[6:2]}
                 + cdc_pkg::WEEKDAY_BIAS - {1'b0, wd_cent, 1'b0};
        n_out.day_now       = r_day;
        n_out.month_now     = r_month;
        n_out.year_now      = r_year;
        n_out.weekday       = cdc_pkg::mod7(wd_sum);
        n_out.load_rejected = r_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day       <= cdc_pkg::RESET_DAY;
            r_month     <= cdc_pkg::RESET_MONTH;
            r_year      <= cdc_pkg::RESET_YEAR;
            r_cent      <= cdc_pkg::RESET_CENTURY;
            r_yic       <= cdc_pkg::RESET_YIC;
            r_rej       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_cent  <= n_cent;
                r_yic   <= n_yic;
                r_rej   <= n_rej;
            end
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_take) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
